// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL file that checks its own logic (lru_keyed_cache.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define LKC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define LKC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/lkc_pkg.sv =====
// Package of types and constants for the LRU keyed cache.
`default_nettype none

package lkc_pkg;

    // Default geometry of the cache
    localparam int ENTRIES_DEF      = 16;
    localparam int KEY_BITS_DEF     = 32;
    localparam int TAG_BITS_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int CAP_RESET  = 16;

    // Request codes
    typedef enum logic [1:0] {
        REQ_GET   = 2'd0,
        REQ_PUT   = 2'd1,
        REQ_FLUSH = 2'd2
    } t_req_type;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAP_LIMIT = 2'd0,
        CFG_TAG_CHECK = 2'd1
    } t_cfg_idx;

    // Per-cell move command along the recency chain
    typedef enum logic [1:0] {
        CO_HOLD  = 2'd0,
        CO_PREV  = 2'd1,
        CO_NEXT  = 2'd2,
        CO_CLEAR = 2'd3
    } t_cell_op;

endpackage

`default_nettype wire

// ===== rtl/lru_keyed_cache.sv =====
// Top level of the fully associative LRU keyed cache.
//
// Usage:
//   Requests enter on start/busy: a request is taken at a clock edge with start
//   high and busy low. i_req_type selects get, put or flush; code 3 changes
//   nothing and reports the current occupancy.
//   Each request gives exactly one result, shown for a single cycle with o_done
//   high. The request executes in the cycle after the accepting edge and o_done
//   is high in the cycle after that. busy is high for the one cycle in which
//   the request executes, so no new request is taken while one executes. The
//   execute cycle compares the key in every cell at once and moves entries one
//   step along the recency chain (cell 0 most recent).
//   Results cannot be held off by the receiver; none is ever dropped or repeated.
//   Configuration writes (capacity limit, tag check) use i_cfg_valid/o_cfg_ready
//   and are made only while no request is in flight.
//   Synchronous reset empties every cell at once; capacity limit returns to 16
//   (clamped to ENTRIES) and tag checking to off. No clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module lru_keyed_cache import lkc_pkg::*; #(
    parameter int ENTRIES      = ENTRIES_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int TAG_BITS     = TAG_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    localparam int CNT_W       = $clog2(ENTRIES + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // request channel
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              i_req_type,
    input  wire logic [KEY_BITS-1:0]     i_req_key,
    input  wire logic [TAG_BITS-1:0]     i_req_tag,
    input  wire logic [PAYLOAD_BITS-1:0] i_req_payload,
    // configuration channel
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    // result channel
    output logic                         o_done,
    output logic                         o_hit,
    output logic                         o_tag_mismatch,
    output logic [PAYLOAD_BITS-1:0]      o_read_payload,
    output logic                         o_duplicate,
    output logic                         o_evicted,
    output logic [KEY_BITS-1:0]          o_evicted_key,
    output logic [PAYLOAD_BITS-1:0]      o_evicted_payload,
    output logic [CNT_W-1:0]             o_used_count
);

    localparam int CAP_RST = (CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET;

    // Request in flight
    logic                    r_exec;
    logic [1:0]              r_type;
    logic [KEY_BITS-1:0]     r_key;
    logic [TAG_BITS-1:0]     r_tag;
    logic [PAYLOAD_BITS-1:0] r_payload;

    // Configuration and occupancy
    logic [CNT_W-1:0]        r_cap_lim;
    logic                    r_tag_chk;
    logic [CNT_W-1:0]        r_occ;
    logic [CNT_W-1:0]        n_occ;

    // Result registers
    logic                    r_done;
    logic                    r_hit;
    logic                    r_tag_mis;
    logic [PAYLOAD_BITS-1:0] r_rd_payload;
    logic                    r_dup;
    logic                    r_evicted;
    logic [KEY_BITS-1:0]     r_ev_key;
    logic [PAYLOAD_BITS-1:0] r_ev_payload;
    logic [CNT_W-1:0]        r_used;

    logic                    n_hit;
    logic                    n_tag_mis;
    logic [PAYLOAD_BITS-1:0] n_rd_payload;
    logic                    n_dup;
    logic                    n_evicted;
    logic [KEY_BITS-1:0]     n_ev_key;
    logic [PAYLOAD_BITS-1:0] n_ev_payload;

    // Cell chain signals
    logic [ENTRIES-1:0]      cell_valid;
    logic [ENTRIES-1:0]      cell_match;
    logic [ENTRIES-1:0]      cell_tag_eq;
    logic [KEY_BITS-1:0]     cell_key     [ENTRIES];
    logic [TAG_BITS-1:0]     cell_tag     [ENTRIES];
    logic [PAYLOAD_BITS-1:0] cell_payload [ENTRIES];
    t_cell_op                cell_op      [ENTRIES];

    logic                    prev_valid   [ENTRIES];
    logic [KEY_BITS-1:0]     prev_key     [ENTRIES];
    logic [TAG_BITS-1:0]     prev_tag     [ENTRIES];
    logic [PAYLOAD_BITS-1:0] prev_payload [ENTRIES];
    logic                    next_valid   [ENTRIES];
    logic [KEY_BITS-1:0]     next_key     [ENTRIES];
    logic [TAG_BITS-1:0]     next_tag     [ENTRIES];
    logic [PAYLOAD_BITS-1:0] next_payload [ENTRIES];

    // Entry pushed into cell 0
    logic [TAG_BITS-1:0]     front_tag;
    logic [PAYLOAD_BITS-1:0] front_payload;

    // Lookup summary
    logic                    hit_any;
    logic                    sel_tag_eq;
    logic [TAG_BITS-1:0]     sel_tag;
    logic [PAYLOAD_BITS-1:0] sel_payload;
    logic [ENTRIES-1:0]      last_valid;
    logic [ENTRIES-1:0]      first_free;
    logic [ENTRIES-1:0]      match_ge;
    logic [ENTRIES-1:0]      match_gt;
    logic [KEY_BITS-1:0]     last_key;
    logic [PAYLOAD_BITS-1:0] last_payload;
    logic                    evict;

    assign busy        = r_exec;
    assign o_cfg_ready = !r_exec;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec <= 1'b0;
        end else begin
            r_exec <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_type    <= i_req_type;
            r_key     <= i_req_key;
            r_tag     <= i_req_tag;
            r_payload <= i_req_payload;
        end
    end

    // Configuration writes; clamp the capacity limit into 1..ENTRIES
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_lim <= CNT_W'(CAP_RST);
            r_tag_chk <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CAP_LIMIT: begin
                    if (i_cfg_data == '0) begin
                        r_cap_lim <= CNT_W'(1);
                    end else if (32'(i_cfg_data) > 32'(ENTRIES)) begin
                        r_cap_lim <= CNT_W'(ENTRIES);
                    end else begin
                        r_cap_lim <= CNT_W'(i_cfg_data);
                    end
                end
                CFG_TAG_CHECK: r_tag_chk <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Neighbour wiring: cell 0 takes the front entry, the last cell sees an empty one
    for (genvar g = 0; g < ENTRIES; g++) begin : g_link
        if (g == 0) begin : g_head
            assign prev_valid[g]   = 1'b1;
            assign prev_key[g]     = r_key;
            assign prev_tag[g]     = front_tag;
            assign prev_payload[g] = front_payload;
        end else begin : g_body
            assign prev_valid[g]   = cell_valid[g-1];
            assign prev_key[g]     = cell_key[g-1];
            assign prev_tag[g]     = cell_tag[g-1];
            assign prev_payload[g] = cell_payload[g-1];
        end
        if (g == ENTRIES - 1) begin : g_tail
            assign next_valid[g]   = 1'b0;
            assign next_key[g]     = '0;
            assign next_tag[g]     = '0;
            assign next_payload[g] = '0;
        end else begin : g_mid
            assign next_valid[g]   = cell_valid[g+1];
            assign next_key[g]     = cell_key[g+1];
            assign next_tag[g]     = cell_tag[g+1];
            assign next_payload[g] = cell_payload[g+1];
        end

        lkc_cell #(
            .KEY_BITS     (KEY_BITS),
            .TAG_BITS     (TAG_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_op           (cell_op[g]),
            .i_prev_valid   (prev_valid[g]),
            .i_prev_key     (prev_key[g]),
            .i_prev_tag     (prev_tag[g]),
            .i_prev_payload (prev_payload[g]),
            .i_next_valid   (next_valid[g]),
            .i_next_key     (next_key[g]),
            .i_next_tag     (next_tag[g]),
            .i_next_payload (next_payload[g]),
            .i_cmp_key      (r_key),
            .i_cmp_tag      (r_tag),
            .o_valid        (cell_valid[g]),
            .o_key          (cell_key[g]),
            .o_tag          (cell_tag[g]),
            .o_payload      (cell_payload[g]),
            .o_match        (cell_match[g]),
            .o_tag_eq       (cell_tag_eq[g])
        );
    end

    // Summarise the lookup: matched entry, last valid cell, first free cell
    always_comb begin
        hit_any      = |cell_match;
        sel_tag_eq   = |(cell_match & cell_tag_eq);
        last_valid   = cell_valid & ~{1'b0, cell_valid[ENTRIES-1:1]};
        first_free   = ~cell_valid & {cell_valid[ENTRIES-2:0], 1'b1};
        evict        = (r_occ >= r_cap_lim);
        sel_tag      = '0;
        sel_payload  = '0;
        last_key     = '0;
        last_payload = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            sel_tag      = sel_tag | ({TAG_BITS{cell_match[i]}} & cell_tag[i]);
            sel_payload  = sel_payload | ({PAYLOAD_BITS{cell_match[i]}} & cell_payload[i]);
            last_key     = last_key | ({KEY_BITS{last_valid[i]}} & cell_key[i]);
            last_payload = last_payload | ({PAYLOAD_BITS{last_valid[i]}} & cell_payload[i]);
            match_ge[i]  = |(cell_match >> i);
            match_gt[i]  = |(cell_match >> (i + 1));
        end
    end

    // Decide the chain moves and the result of the request in flight
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            cell_op[i] = CO_HOLD;
        end
        front_tag     = r_tag;
        front_payload = r_payload;
        n_occ         = r_occ;
        n_hit         = 1'b0;
        n_tag_mis     = 1'b0;
        n_rd_payload  = '0;
        n_dup         = 1'b0;
        n_evicted     = 1'b0;
        n_ev_key      = '0;
        n_ev_payload  = '0;
        if (r_exec) begin
            case (r_type)
                REQ_GET: begin
                    if (hit_any) begin
                        if (r_tag_chk && !sel_tag_eq) begin
                            // close the gap left by the removed entry
                            for (int i = 0; i < ENTRIES; i++) begin
                                if (!match_gt[i]) begin
                                    cell_op[i] = CO_NEXT;
                                end
                            end
                            n_occ     = r_occ - CNT_W'(1);
                            n_tag_mis = 1'b1;
                        end else begin
                            // move the hit entry to the front
                            for (int i = 0; i < ENTRIES; i++) begin
                                if (match_ge[i]) begin
                                    cell_op[i] = CO_PREV;
                                end
                            end
                            front_tag     = sel_tag;
                            front_payload = sel_payload;
                            n_hit         = 1'b1;
                            n_rd_payload  = sel_payload;
                        end
                    end
                end
                REQ_PUT: begin
                    if (hit_any) begin
                        // keep the stored entry, only refresh its recency
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (match_ge[i]) begin
                                cell_op[i] = CO_PREV;
                            end
                        end
                        front_tag     = sel_tag;
                        front_payload = sel_payload;
                        n_dup         = 1'b1;
                    end else begin
                        // push the new entry in; the last valid one drops out once the capacity limit is reached
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (cell_valid[i] || (first_free[i] && !evict)) begin
                                cell_op[i] = CO_PREV;
                            end
                        end
                        if (evict) begin
                            n_evicted    = 1'b1;
                            n_ev_key     = last_key;
                            n_ev_payload = last_payload;
                        end else begin
                            n_occ = r_occ + CNT_W'(1);
                        end
                    end
                end
                REQ_FLUSH: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        cell_op[i] = CO_CLEAR;
                    end
                    n_occ = '0;
                end
                default: ;
            endcase
        end
    end

    // Occupancy and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_done <= 1'b0;
        end else begin
            r_occ  <= n_occ;
            r_done <= r_exec;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (r_exec) begin
            r_hit        <= n_hit;
            r_tag_mis    <= n_tag_mis;
            r_rd_payload <= n_rd_payload;
            r_dup        <= n_dup;
            r_evicted    <= n_evicted;
            r_ev_key     <= n_ev_key;
            r_ev_payload <= n_ev_payload;
            r_used       <= n_occ;
        end
    end

    assign o_done            = r_done;
    assign o_hit             = r_hit;
    assign o_tag_mismatch    = r_tag_mis;
    assign o_read_payload    = r_rd_payload;
    assign o_duplicate       = r_dup;
    assign o_evicted         = r_evicted;
    assign o_evicted_key     = r_ev_key;
    assign o_evicted_payload = r_ev_payload;
    assign o_used_count      = r_used;

    // Checks on the chain and the result
    `LKC_ASSERT(a_occ_matches_cells, r_occ == CNT_W'($countones(cell_valid)), "occupancy off")
    `LKC_ASSERT(a_cells_packed, (cell_valid & (cell_valid + ENTRIES'(1))) == '0, "cells unpacked")
    `LKC_ASSERT(a_single_match, $onehot0(cell_match), "key found in more than one cell")
    `LKC_ASSERT(a_result_follows, r_exec |=> o_done && !busy, "executed request gave no result")
    `LKC_ASSERT(a_one_outcome, o_done |-> $onehot0({o_hit, o_tag_mismatch, o_duplicate, o_evicted}), "outcome flags clash")

endmodule

`default_nettype wire

// ===== rtl/lkc_cell.sv =====
// One recency cell: holds an entry and moves it along the chain on command.
`default_nettype none

module lkc_cell import lkc_pkg::*; #(
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int TAG_BITS     = TAG_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cell_op                i_op,
    input  wire logic                    i_prev_valid,
    input  wire logic [KEY_BITS-1:0]     i_prev_key,
    input  wire logic [TAG_BITS-1:0]     i_prev_tag,
    input  wire logic [PAYLOAD_BITS-1:0] i_prev_payload,
    input  wire logic                    i_next_valid,
    input  wire logic [KEY_BITS-1:0]     i_next_key,
    input  wire logic [TAG_BITS-1:0]     i_next_tag,
    input  wire logic [PAYLOAD_BITS-1:0] i_next_payload,
    input  wire logic [KEY_BITS-1:0]     i_cmp_key,
    input  wire logic [TAG_BITS-1:0]     i_cmp_tag,
    output logic                         o_valid,
    output logic [KEY_BITS-1:0]          o_key,
    output logic [TAG_BITS-1:0]          o_tag,
    output logic [PAYLOAD_BITS-1:0]      o_payload,
    output logic                         o_match,
    output logic                         o_tag_eq
);

    logic                    r_valid;
    logic [KEY_BITS-1:0]     r_key;
    logic [TAG_BITS-1:0]     r_tag;
    logic [PAYLOAD_BITS-1:0] r_payload;

    // Take the entry from a neighbour, drop it, or hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_op)
                CO_PREV:  r_valid <= i_prev_valid;
                CO_NEXT:  r_valid <= i_next_valid;
                CO_CLEAR: r_valid <= 1'b0;
                default:  r_valid <= r_valid;
            endcase
        end
    end

    // Entry contents follow the same moves; no reset needed
    always_ff @(posedge i_clk) begin
        case (i_op)
            CO_PREV: begin
                r_key     <= i_prev_key;
                r_tag     <= i_prev_tag;
                r_payload <= i_prev_payload;
            end
            CO_NEXT: begin
                r_key     <= i_next_key;
                r_tag     <= i_next_tag;
                r_payload <= i_next_payload;
            end
            default: begin
                r_key     <= r_key;
                r_tag     <= r_tag;
                r_payload <= r_payload;
            end
        endcase
    end

    // Compare against the request in flight
    assign o_match   = r_valid && (r_key == i_cmp_key);
    assign o_tag_eq  = (r_tag == i_cmp_tag);
    assign o_valid   = r_valid;
    assign o_key     = r_key;
    assign o_tag     = r_tag;
    assign o_payload = r_payload;

endmodule

`default_nettype wire

// ===== tb/lru_keyed_cache_tb.sv =====
// Self-checking testbench for the LRU keyed cache against a shadow cache model.
`timescale 1ns / 100ps

module lru_keyed_cache_tb;
    import lkc_pkg::*;

    localparam int SLOTS     = ENTRIES_DEF;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int KEY_POOL  = 32;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 66;

    // Request code outside the package list: the cache must leave its state alone
    localparam logic [1:0] REQ_NONE = 2'd3;
    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [15:0] tag;
        logic [31:0] payload;
    } t_cache_request;

    typedef struct {
        logic             hit;
        logic             tag_mismatch;
        logic [31:0]      read_payload;
        logic             duplicate;
        logic             evicted;
        logic [31:0]      evicted_key;
        logic [31:0]      evicted_payload;
        logic [CNT_W-1:0] used_count;
    } t_cache_result;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic [1:0]            i_req_type     = REQ_GET;
    logic [31:0]           i_req_key      = '0;
    logic [15:0]           i_req_tag      = '0;
    logic [31:0]           i_req_payload  = '0;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_CAP_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_done;
    logic                  o_hit;
    logic                  o_tag_mismatch;
    logic [31:0]           o_read_payload;
    logic                  o_duplicate;
    logic                  o_evicted;
    logic [31:0]           o_evicted_key;
    logic [31:0]           o_evicted_payload;
    logic [CNT_W-1:0]      o_used_count;

    lru_keyed_cache dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_req_key         (i_req_key),
        .i_req_tag         (i_req_tag),
        .i_req_payload     (i_req_payload),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_done            (o_done),
        .o_hit             (o_hit),
        .o_tag_mismatch    (o_tag_mismatch),
        .o_read_payload    (o_read_payload),
        .o_duplicate       (o_duplicate),
        .o_evicted         (o_evicted),
        .o_evicted_key     (o_evicted_key),
        .o_evicted_payload (o_evicted_payload),
        .o_used_count      (o_used_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Shadow copy of the cache contents and registers
    bit               slot_valid   [SLOTS];
    logic [31:0]      slot_key     [SLOTS];
    logic [15:0]      slot_tag     [SLOTS];
    logic [31:0]      slot_payload [SLOTS];
    int unsigned      slot_rank    [SLOTS];
    int unsigned      occupancy    = 0;
    logic [4:0]       capacity_reg = 5'd16;
    bit               tag_check_reg = 1'b0;

    t_cache_request   queued_requests[$];
    t_cache_result    predicted_replies[$];
    t_cache_request   in_service;
    int unsigned      sender_idle_pct = 0;
    int unsigned      issued_count    = 0;
    int unsigned      replies_seen    = 0;
    int unsigned      failures        = 0;
    int unsigned      hits_seen       = 0;
    int unsigned      drops_seen      = 0;
    int unsigned      dups_seen       = 0;
    int unsigned      evictions_seen  = 0;
    logic [31:0]      key_pool [KEY_POOL];
    logic [15:0]      tag_pool [KEY_POOL];

    // Make slot s most recent, ageing every entry that was newer
    function automatic void promote_slot(int s);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_rank[i] < slot_rank[s])
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    // Remove slot s and close the gap in the recency order
    function automatic void drop_slot(int s);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && i != s && slot_rank[i] > slot_rank[s])
                slot_rank[i]--;
        slot_valid[s] = 1'b0;
        slot_rank[s]  = 0;
        if (occupancy > 0)
            occupancy--;
    endfunction

    function automatic int find_slot(logic [31:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    // Apply one request to the shadow cache and return the reply it must give
    function automatic t_cache_result shadow_access(t_cache_request req);
        t_cache_result res;
        int            s;
        int            lru;
        int unsigned   lim;
        res = '{default: '0};
        case (req.kind)
            REQ_GET: begin
                s = find_slot(req.key);
                if (s >= 0) begin
                    if (tag_check_reg && slot_tag[s] != req.tag) begin
                        drop_slot(s);
                        res.tag_mismatch = 1'b1;
                    end else begin
                        promote_slot(s);
                        res.hit          = 1'b1;
                        res.read_payload = slot_payload[s];
                    end
                end
            end
            REQ_PUT: begin
                s = find_slot(req.key);
                if (s >= 0) begin
                    promote_slot(s);
                    res.duplicate = 1'b1;
                end else begin
                    // clamp the limit into 1..SLOTS
                    lim = 32'(capacity_reg);
                    if (lim == 0)
                        lim = 1;
                    if (lim > SLOTS)
                        lim = SLOTS;
                    if (occupancy >= lim) begin
                        lru = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_valid[i] && (lru < 0 || slot_rank[i] > slot_rank[lru]))
                                lru = i;
                        if (lru >= 0) begin
                            res.evicted         = 1'b1;
                            res.evicted_key     = slot_key[lru];
                            res.evicted_payload = slot_payload[lru];
                            drop_slot(lru);
                        end
                    end
                    // insert into the lowest free slot as most recent
                    s = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (!slot_valid[i] && s < 0)
                            s = i;
                    if (s >= 0) begin
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_valid[i])
                                slot_rank[i]++;
                        slot_valid[s]   = 1'b1;
                        slot_key[s]     = req.key;
                        slot_tag[s]     = req.tag;
                        slot_payload[s] = req.payload;
                        slot_rank[s]    = 0;
                        occupancy++;
                    end
                end
            end
            REQ_FLUSH: begin
                for (int i = 0; i < SLOTS; i++) begin
                    slot_valid[i] = 1'b0;
                    slot_rank[i]  = 0;
                end
                occupancy = 0;
            end
            default: ;
        endcase
        res.used_count = CNT_W'(occupancy);
        return res;
    endfunction

    function automatic void queue_request(logic [1:0] kind, logic [31:0] key,
                                          logic [15:0] tag, logic [31:0] payload);
        t_cache_request req;
        req.kind    = kind;
        req.key     = key;
        req.tag     = tag;
        req.payload = payload;
        queued_requests.push_back(req);
        issued_count++;
    endfunction

    // Mostly keys from a small pool so that hits, duplicates and evictions occur
    function automatic void queue_random_request(int span);
        int unsigned roll;
        int unsigned idx;
        logic [1:0]  kind;
        logic [31:0] key;
        logic [15:0] tag;
        logic [31:0] payload;
        roll = $urandom_range(99);
        if (roll < 47)
            kind = REQ_GET;
        else if (roll < 97)
            kind = REQ_PUT;
        else if (roll < 98)
            kind = REQ_FLUSH;
        else
            kind = REQ_NONE;
        idx = $urandom_range(span - 1);
        if ($urandom_range(99) < 88) begin
            key = key_pool[idx];
            tag = ($urandom_range(99) < ((kind == REQ_PUT) ? 90 : 80)) ? tag_pool[idx]
                                                                       : 16'($urandom());
        end else begin
            key = $urandom();
            tag = 16'($urandom());
        end
        roll = $urandom_range(99);
        if (roll < 3)
            payload = '0;
        else if (roll < 6)
            payload = '1;
        else
            payload = $urandom();
        queue_request(kind, key, tag, payload);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            failures++;
        end
    endfunction

    // Write one register over the configuration channel while the cache is idle
    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (index == CFG_CAP_LIMIT)
            capacity_reg = value;
        else if (index == CFG_TAG_CHECK)
            tag_check_reg = value[0];
    endtask

    // Hold until every issued request has been answered, then let the pipeline settle
    task automatic wait_for_replies();
        while (replies_seen != issued_count)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Request driver: hold start until taken, then advance to the next request or idle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                predicted_replies.push_back(shadow_access(in_service));
            if (!start || !busy) begin
                if (queued_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    in_service     = queued_requests.pop_front();
                    start         <= 1'b1;
                    i_req_type    <= in_service.kind;
                    i_req_key     <= in_service.key;
                    i_req_tag     <= in_service.tag;
                    i_req_payload <= in_service.payload;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each strobed reply with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_cache_result want;
        if (i_rst_n && o_done) begin
            replies_seen++;
            hits_seen      += 32'(o_hit);
            drops_seen     += 32'(o_tag_mismatch);
            dups_seen      += 32'(o_duplicate);
            evictions_seen += 32'(o_evicted);
            if (predicted_replies.size() == 0) begin
                $display("%0t: reply with nothing outstanding: expected none, actual used %0d",
                         $time, o_used_count);
                failures++;
            end else begin
                want = predicted_replies.pop_front();
                check_field("hit", 32'(want.hit), 32'(o_hit));
                check_field("tag_mismatch", 32'(want.tag_mismatch), 32'(o_tag_mismatch));
                check_field("read_payload", want.read_payload, o_read_payload);
                check_field("duplicate", 32'(want.duplicate), 32'(o_duplicate));
                check_field("evicted", 32'(want.evicted), 32'(o_evicted));
                check_field("evicted_key", want.evicted_key, o_evicted_key);
                check_field("evicted_payload", want.evicted_payload, o_evicted_payload);
                check_field("used_count", 32'(want.used_count), 32'(o_used_count));
            end
        end
    end

    // Stimulus: directed corners, then random phases over a range of register settings
    initial begin : stimulus
        logic [4:0]  cap_plan [PHASES];
        bit          tag_plan [PHASES];
        int unsigned idle_plan [3];
        int          span;
        cap_plan  = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd8, 5'd17, 5'd2};
        tag_plan  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        idle_plan = '{0, 45, 10};
        key_pool[0] = '0;
        tag_pool[0] = '0;
        key_pool[1] = '1;
        tag_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++) begin
            key_pool[i] = $urandom();
            tag_pool[i] = 16'($urandom());
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: misses, extreme keys, duplicates, unknown code, flush
        queue_request(REQ_GET,   32'h0000_0000, 16'h0000, 32'h0000_0000);
        queue_request(REQ_PUT,   32'h0000_0000, 16'h0000, 32'h0000_0000);
        queue_request(REQ_PUT,   32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_request(REQ_GET,   32'hFFFF_FFFF, 16'h0000, 32'h1234_5678);
        queue_request(REQ_PUT,   32'h0000_0000, 16'hFFFF, 32'hFFFF_FFFF);
        queue_request(REQ_GET,   32'h0000_0000, 16'h1234, 32'h0000_0000);
        queue_request(REQ_NONE,  32'h0000_0000, 16'h0000, 32'hDEAD_BEEF);
        queue_request(REQ_FLUSH, 32'h0000_0000, 16'h0000, 32'h0000_0000);
        queue_request(REQ_GET,   32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000);
        wait_for_replies();

        // Two slots with tag checking: evictions in LRU order and tag drops
        write_register(CFG_SPARE, 5'h1F);
        write_register(CFG_CAP_LIMIT, 5'd2);
        write_register(CFG_TAG_CHECK, 5'd1);
        queue_request(REQ_PUT,   32'h0000_0001, 16'hAAAA, 32'h1111_1111);
        queue_request(REQ_PUT,   32'h8000_0000, 16'h5555, 32'h2222_2222);
        queue_request(REQ_PUT,   32'h5555_5555, 16'h0F0F, 32'h3333_3333);
        queue_request(REQ_GET,   32'h8000_0000, 16'h5555, 32'h0000_0000);
        queue_request(REQ_PUT,   32'hAAAA_AAAA, 16'hF0F0, 32'h4444_4444);
        queue_request(REQ_GET,   32'h8000_0000, 16'h0000, 32'h0000_0000);
        queue_request(REQ_GET,   32'h8000_0000, 16'h5555, 32'h0000_0000);
        queue_request(REQ_PUT,   32'h8000_0000, 16'h5555, 32'h5555_5555);
        queue_request(REQ_PUT,   32'h8000_0000, 16'h1111, 32'h6666_6666);
        queue_request(REQ_GET,   32'hAAAA_AAAA, 16'hF0F0, 32'h0000_0000);
        queue_request(REQ_FLUSH, 32'h0000_0000, 16'h0000, 32'h0000_0000);
        queue_request(REQ_NONE,  32'hAAAA_AAAA, 16'hF0F0, 32'h0000_0000);
        wait_for_replies();

        // Random phases; the limit drops below occupancy between the first two
        for (int p = 0; p < PHASES; p++) begin
            write_register(CFG_CAP_LIMIT, cap_plan[p]);
            write_register(CFG_TAG_CHECK, {4'b0, tag_plan[p]});
            sender_idle_pct = idle_plan[p % 3];
            span = (cap_plan[p] == 5'd0) ? 1
                 : (cap_plan[p] > 5'(SLOTS)) ? SLOTS : int'(cap_plan[p]);
            span = span + 4;
            for (int n = 0; n < PHASE_LEN; n++)
                queue_random_request(span);
            wait_for_replies();
        end

        $display("Checked %0d replies over %0d register settings and three idle patterns.",
                 replies_seen, PHASES + 2);
        $display("Seen: %0d hits, %0d tag drops, %0d duplicate puts, %0d evictions.",
                 hits_seen, drops_seen, dups_seen, evictions_seen);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog against a hung handshake
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lkc_pkg.sv
rtl/lkc_cell.sv
rtl/lru_keyed_cache.sv
tb/lru_keyed_cache_tb.sv
